// ===== src/nfba_pkg.sv =====
// Package for the next-fit block allocator: sizes, codes, table entry
// and transfer payload types. No dependencies.
`timescale 1ns / 1ps
package nfba_pkg;

  localparam int MAX_ENTRIES = 32;
  localparam int ADDR_BITS   = 20;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int SIZE_W      = ADDR_BITS + 1;
  localparam int SUM_W       = SIZE_W + 1;

  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_FREE   = 2'd1;
  localparam logic [1:0] OP_DEFRAG = 2'd2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_ZERO    = 3'd1;
  localparam logic [2:0] ST_NO_MEM  = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_UNKNOWN = 3'd4;

  localparam logic [SIZE_W-1:0] BUF_RESET = SIZE_W'(65536);
  localparam logic [SIZE_W-1:0] BUF_CAP   = SIZE_W'(1) << ADDR_BITS;

  typedef struct packed {
    logic [ADDR_BITS-1:0] start;
    logic [SIZE_W-1:0]    size;
    logic                 used;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [1:0]  operation;
    logic [20:0] request_size;
    logic [19:0] free_start;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [19:0] old_start;
    logic [19:0] new_start;
    logic [20:0] block_size;
    logic        last;
  } out_item_t;

endpackage

// ===== src/next_fit_block_allocator_unit.sv =====
// Next-fit block allocator top level: control sequencer around the block table.
// Depends on nfba_pkg and nfba_ram.
`timescale 1ns / 1ps
// The block table lives in one RAM with registered read data; every table
// read takes a read state followed by a processing state. Free scans entries
// until it finds the block, defragment walks every table entry. Allocate scans
// from each candidate start through its free run, then shifts entries, with a
// read state and a write state each, on merge or split. Results appear on
// result with done high for one cycle and cannot be held off; defragment gives
// one result per kept block, or one zero-size result if none is kept. After reset
// and after each buffer_size write the unit is busy while it rebuilds the table.
module next_fit_block_allocator_unit
  import nfba_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  in_item_t          cmd,
  output logic              done,
  output out_item_t         result,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_wdata
);

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_A_RD, S_A_DAT, S_A_CHK, S_SD_RD, S_SD_WR, S_SU_RD,
    S_SU_WR, S_A_W1, S_A_W0, S_F_RD, S_F_DAT, S_D_RD, S_D_DAT, S_D_END
  } state_t;

  state_t                state;
  logic [SIZE_W-1:0]     buf_size;
  logic [CNT_W-1:0]      cnt;
  logic [IDX_W-1:0]      pos;
  logic [SIZE_W-1:0]     req;
  logic [ADDR_BITS-1:0]  fs;
  logic [CNT_W-1:0]      j, k, m, w;
  logic [IDX_W-1:0]      si;
  logic [IDX_W-1:0]      s;
  logic [SUM_W-1:0]      total;
  logic [SIZE_W-1:0]     nxt;
  logic [ADDR_BITS-1:0]  sst;
  logic [CNT_W-1:0]      removed, newcnt;
  logic [SUM_W-1:0]      extra;
  logic                  pend_v;
  out_item_t             pend;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr, ram_raddr;
  entry_t                ram_wdata, ram_rdata;

  logic [CNT_W-1:0]      rem_c, ncnt_c, fcnt_c, s_inc;
  logic [SUM_W-1:0]      ext_c;
  logic [IDX_W-1:0]      si_nx;
  logic [SIZE_W-1:0]     cfg_v;

  nfba_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_ENTRIES)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  function automatic out_item_t mk(logic [2:0] st, logic [ADDR_BITS-1:0] os,
                                   logic [ADDR_BITS-1:0] ns,
                                   logic [SIZE_W-1:0] sz, logic lst);
    out_item_t r;
    r.status     = st;
    r.old_start  = os;
    r.new_start  = ns;
    r.block_size = sz;
    r.last       = lst;
    return r;
  endfunction

  assign busy   = (state != S_IDLE) || cfg_we;
  assign rem_c  = j - CNT_W'(1) - CNT_W'(si);
  assign ncnt_c = cnt - rem_c;
  assign ext_c  = total - SUM_W'(req);
  assign si_nx  = (CNT_W'(si) + CNT_W'(1) == cnt) ? '0 : si + IDX_W'(1);
  assign fcnt_c = newcnt + ((extra != '0) ? CNT_W'(1) : CNT_W'(0));
  assign s_inc  = CNT_W'(s) + CNT_W'(1);

  always_comb begin
    cfg_v = cfg_wdata;
    if (cfg_wdata == '0) begin
      cfg_v = SIZE_W'(1);
    end else if (cfg_wdata > BUF_CAP) begin
      cfg_v = BUF_CAP;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = ram_rdata;
    ram_raddr = '0;
    unique case (state)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = '{start: '0, size: buf_size, used: 1'b0};
      end
      S_A_RD:  ram_raddr = j[IDX_W-1:0];
      S_SD_RD: ram_raddr = m[IDX_W-1:0];
      S_SD_WR: begin
        ram_we    = 1'b1;
        ram_waddr = IDX_W'(m - CNT_W'(1) - removed);
      end
      S_SU_RD: ram_raddr = IDX_W'(m - CNT_W'(1));
      S_SU_WR: begin
        ram_we    = 1'b1;
        ram_waddr = m[IDX_W-1:0];
      end
      S_A_W1: begin
        ram_we    = 1'b1;
        ram_waddr = s + IDX_W'(1);
        ram_wdata = '{start: sst + ADDR_BITS'(req), size: SIZE_W'(extra), used: 1'b0};
      end
      S_A_W0: begin
        ram_we    = 1'b1;
        ram_waddr = s;
        ram_wdata = '{start: sst, size: req, used: 1'b1};
      end
      S_F_RD:  ram_raddr = j[IDX_W-1:0];
      S_F_DAT: begin
        ram_we    = ram_rdata.used && (ram_rdata.start == fs);
        ram_waddr = IDX_W'(j);
        ram_wdata = '{start: ram_rdata.start, size: ram_rdata.size, used: 1'b0};
      end
      S_D_RD:  ram_raddr = j[IDX_W-1:0];
      S_D_DAT: begin
        ram_we    = ram_rdata.used;
        ram_waddr = w[IDX_W-1:0];
        ram_wdata = '{start: ADDR_BITS'(nxt), size: ram_rdata.size, used: 1'b1};
      end
      S_D_END: begin
        ram_we    = (w < CNT_W'(MAX_ENTRIES));
        ram_waddr = w[IDX_W-1:0];
        ram_wdata = '{start: ADDR_BITS'(nxt), size: SIZE_W'(total) - nxt, used: 1'b0};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      buf_size <= BUF_RESET;
      cnt      <= CNT_W'(1);
      pos      <= '0;
      done     <= 1'b0;
      pend_v   <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_INIT: begin
          cnt   <= CNT_W'(1);
          pos   <= '0;
          state <= S_IDLE;
        end
        S_IDLE: begin
          if (cfg_we) begin
            buf_size <= cfg_v;
            state    <= S_INIT;
          end else if (start) begin
            req   <= cmd.request_size;
            fs    <= cmd.free_start;
            total <= '0;
            j     <= '0;
            k     <= '0;
            case (cmd.operation)
              OP_ALLOC: begin
                if (cmd.request_size == '0) begin
                  result <= mk(ST_ZERO, '0, '0, '0, 1'b1);
                  done   <= 1'b1;
                end else begin
                  si    <= (CNT_W'(pos) >= cnt) ? '0 : pos;
                  j     <= (CNT_W'(pos) >= cnt) ? '0 : CNT_W'(pos);
                  state <= S_A_RD;
                end
              end
              OP_FREE: state <= S_F_RD;
              OP_DEFRAG: begin
                w      <= '0;
                nxt    <= '0;
                pend_v <= 1'b0;
                state  <= S_D_RD;
              end
              default: ;
            endcase
          end
        end
        S_A_RD: begin
          if (j < cnt && total < SUM_W'(req)) begin
            state <= S_A_DAT;
          end else begin
            state <= S_A_CHK;
          end
        end
        S_A_DAT: begin
          if (j == CNT_W'(si)) begin
            sst <= ram_rdata.start;
          end
          if (ram_rdata.used) begin
            state <= S_A_CHK;
          end else begin
            total <= total + SUM_W'(ram_rdata.size);
            j     <= j + CNT_W'(1);
            state <= S_A_RD;
          end
        end
        S_A_CHK: begin
          if (total >= SUM_W'(req)) begin
            s       <= si;
            removed <= rem_c;
            newcnt  <= ncnt_c;
            extra   <= ext_c;
            m       <= j;
            if (ext_c != '0 && ncnt_c >= CNT_W'(MAX_ENTRIES)) begin
              result <= mk(ST_FULL, '0, '0, '0, 1'b1);
              done   <= 1'b1;
              state  <= S_IDLE;
            end else begin
              state <= S_SD_RD;
            end
          end else if (k + CNT_W'(1) == cnt) begin
            result <= mk(ST_NO_MEM, '0, '0, '0, 1'b1);
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            k     <= k + CNT_W'(1);
            si    <= si_nx;
            j     <= CNT_W'(si_nx);
            total <= '0;
            state <= S_A_RD;
          end
        end
        S_SD_RD: begin
          if (removed != '0 && m < cnt) begin
            m     <= m + CNT_W'(1);
            state <= S_SD_WR;
          end else if (extra != '0) begin
            m     <= newcnt;
            state <= S_SU_RD;
          end else begin
            state <= S_A_W0;
          end
        end
        S_SD_WR: state <= S_SD_RD;
        S_SU_RD: begin
          if (m > s_inc) begin
            state <= S_SU_WR;
          end else begin
            state <= S_A_W1;
          end
        end
        S_SU_WR: begin
          m     <= m - CNT_W'(1);
          state <= S_SU_RD;
        end
        S_A_W1: state <= S_A_W0;
        S_A_W0: begin
          cnt    <= fcnt_c;
          pos    <= (s_inc >= fcnt_c) ? '0 : IDX_W'(s_inc);
          result <= mk(ST_OK, sst, sst, req, 1'b1);
          done   <= 1'b1;
          state  <= S_IDLE;
        end
        S_F_RD: begin
          if (j < cnt) begin
            state <= S_F_DAT;
          end else begin
            result <= mk(ST_UNKNOWN, '0, '0, '0, 1'b1);
            done   <= 1'b1;
            state  <= S_IDLE;
          end
        end
        S_F_DAT: begin
          if (ram_rdata.used && ram_rdata.start == fs) begin
            result <= mk(ST_OK, fs, fs, ram_rdata.size, 1'b1);
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            j     <= j + CNT_W'(1);
            state <= S_F_RD;
          end
        end
        S_D_RD: begin
          state <= (j < cnt) ? S_D_DAT : S_D_END;
        end
        S_D_DAT: begin
          total <= total + SUM_W'(ram_rdata.size);
          j     <= j + CNT_W'(1);
          if (ram_rdata.used) begin
            if (pend_v) begin
              result <= pend;
              done   <= 1'b1;
            end
            pend_v <= 1'b1;
            pend   <= mk(ST_OK, ram_rdata.start, ADDR_BITS'(nxt), ram_rdata.size, 1'b0);
            nxt    <= nxt + ram_rdata.size;
            w      <= w + CNT_W'(1);
          end
          state <= S_D_RD;
        end
        S_D_END: begin
          if (w < CNT_W'(MAX_ENTRIES)) begin
            cnt <= w + CNT_W'(1);
            pos <= w[IDX_W-1:0];
          end else begin
            cnt <= w;
            pos <= '0;
          end
          result <= pend_v ? mk(ST_OK, pend.old_start, pend.new_start, pend.block_size, 1'b1)
                           : mk(ST_OK, '0, '0, '0, 1'b1);
          done   <= 1'b1;
          pend_v <= 1'b0;
          state  <= S_IDLE;
        end
        default: state <= S_INIT;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt >= CNT_W'(1) && cnt <= CNT_W'(MAX_ENTRIES))
    else $error("entry count out of range");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    CNT_W'(pos) < cnt)
    else $error("search position beyond table");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done && result.last |-> !busy)
    else $error("final transfer while still working");
`endif

endmodule

// ===== src/nfba_ram.sv =====
// Generic RAM: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps
module nfba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench for next_fit_block_allocator_unit: drives allocate, free and
// defragment commands and buffer_size writes, checks every result transfer.
// Depends on nfba_pkg and the unit RTL.
`timescale 1ns / 1ps

module tb
  import nfba_pkg::*;
();

  class alloc_scoreboard;
    logic [ADDR_BITS-1:0] tbl_start[MAX_ENTRIES];
    logic [SIZE_W-1:0]    tbl_size[MAX_ENTRIES];
    bit                   tbl_used[MAX_ENTRIES];
    int                   tbl_count;
    int                   scan_pos;
    logic [SIZE_W-1:0]    buf_bytes;
    out_item_t            pending[$];
    int                   errors;
    int                   results_seen;

    function new();
      errors = 0;
      results_seen = 0;
      buf_bytes = BUF_RESET;
      rebuild();
    endfunction

    function void rebuild();
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        tbl_start[i] = '0;
        tbl_size[i] = '0;
        tbl_used[i] = 0;
      end
      tbl_size[0] = buf_bytes;
      tbl_count = 1;
      scan_pos = 0;
    endfunction

    function void set_buffer(logic [SIZE_W-1:0] v);
      if (v == 0) v = 1;
      if (v > BUF_CAP) v = BUF_CAP;
      buf_bytes = v;
      rebuild();
    endfunction

    function void push(logic [2:0] st, logic [19:0] os, logic [19:0] ns,
                       logic [20:0] sz);
      out_item_t r;
      r.status = st;
      r.old_start = os;
      r.new_start = ns;
      r.block_size = sz;
      r.last = 0;
      pending = {pending, r};
    endfunction

    function void allocate(logic [20:0] req);
      int s, e, removed, newcnt, i, j;
      longint total, extra;
      bit found;
      s = 0; e = 0; total = 0; found = 0;
      if (req == 0) begin
        push(ST_ZERO, 0, 0, 0);
        return;
      end
      for (int k = 0; k < tbl_count && !found; k++) begin
        i = (scan_pos + k) % tbl_count;
        j = i;
        if (tbl_used[i]) continue;
        total = 0;
        while (j < tbl_count && total < req && !tbl_used[j]) begin
          total += tbl_size[j];
          j++;
        end
        if (total >= req) begin
          found = 1; s = i; e = j;
        end
      end
      if (!found) begin
        push(ST_NO_MEM, 0, 0, 0);
        return;
      end
      removed = e - 1 - s;
      newcnt = tbl_count - removed;
      extra = total - req;
      if (extra > 0 && newcnt >= MAX_ENTRIES) begin
        push(ST_FULL, 0, 0, 0);
        return;
      end
      tbl_size[s] = total;
      for (int m = e; m < tbl_count; m++) begin
        tbl_start[m - removed] = tbl_start[m];
        tbl_size[m - removed] = tbl_size[m];
        tbl_used[m - removed] = tbl_used[m];
      end
      if (extra > 0) begin
        for (int m = newcnt; m > s + 1; m--) begin
          tbl_start[m] = tbl_start[m - 1];
          tbl_size[m] = tbl_size[m - 1];
          tbl_used[m] = tbl_used[m - 1];
        end
        tbl_start[s + 1] = tbl_start[s] + req;
        tbl_size[s + 1] = extra;
        tbl_used[s + 1] = 0;
        tbl_size[s] = req;
        newcnt++;
      end
      tbl_used[s] = 1;
      tbl_count = newcnt;
      scan_pos = (s + 1 >= newcnt) ? 0 : s + 1;
      push(ST_OK, tbl_start[s], tbl_start[s], req);
    endfunction

    function void release_block(logic [19:0] addr);
      for (int i = 0; i < tbl_count; i++)
        if (tbl_used[i] && tbl_start[i] == addr) begin
          tbl_used[i] = 0;
          push(ST_OK, addr, addr, tbl_size[i]);
          return;
        end
      push(ST_UNKNOWN, 0, 0, 0);
    endfunction

    function void compact();
      int w, n;
      longint nxt, total;
      logic [19:0] old;
      logic [20:0] sz;
      w = 0; n = 0; nxt = 0; total = 0;
      for (int i = 0; i < tbl_count; i++) begin
        total += tbl_size[i];
        if (tbl_used[i]) begin
          old = tbl_start[i];
          sz = tbl_size[i];
          tbl_start[w] = nxt;
          tbl_size[w] = sz;
          tbl_used[w] = 1;
          push(ST_OK, old, nxt, sz);
          n++;
          nxt += sz;
          w++;
        end
      end
      if (w < MAX_ENTRIES) begin
        tbl_start[w] = nxt;
        tbl_size[w] = total - nxt;
        tbl_used[w] = 0;
        tbl_count = w + 1;
        scan_pos = w;
      end else begin
        tbl_count = w;
        scan_pos = 0;
      end
      if (n == 0) push(ST_OK, 0, 0, 0);
    endfunction

    // queues the results the command produces
    function void note_command(in_item_t c);
      if (scan_pos >= tbl_count) scan_pos = 0;
      case (c.operation)
        OP_ALLOC:  allocate(c.request_size);
        OP_FREE:   release_block(c.free_start);
        OP_DEFRAG: compact();
        default:   return;
      endcase
      pending[$].last = 1;
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      results_seen++;
      if (pending.size() == 0) begin
        $error("unexpected result transfer %p", got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got.status); errors++;
      end
      if (got.old_start !== exp.old_start) begin
        $error("old_start: expected %0h, got %0h", exp.old_start, got.old_start); errors++;
      end
      if (got.new_start !== exp.new_start) begin
        $error("new_start: expected %0h, got %0h", exp.new_start, got.new_start); errors++;
      end
      if (got.block_size !== exp.block_size) begin
        $error("block_size: expected %0h, got %0h", exp.block_size, got.block_size);
        errors++;
      end
      if (got.last !== exp.last) begin
        $error("last: expected %0d, got %0d", exp.last, got.last); errors++;
      end
    endfunction
  endclass

  localparam longint CYCLE_LIMIT = 2000000;

  logic              clk = 0;
  logic              rst = 1;
  logic              start = 0;
  logic              busy;
  in_item_t          cmd = '0;
  logic              done;
  out_item_t         result;
  logic              cfg_we = 0;
  logic [SIZE_W-1:0] cfg_wdata = '0;

  alloc_scoreboard   sb;
  longint            cycles = 0;
  bit                quiet_stretch = 0;
  int                sent = 0;

  next_fit_block_allocator_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk)
    if (!rst && done) sb.check_result(result);

  // start stays high after a transfer until the next call or drain decides
  task automatic send(in_item_t c);
    if (!quiet_stretch)
      while ($urandom_range(99) < 24) begin
        start <= 0;
        @(posedge clk);
      end
    start <= 1;
    cmd <= c;
    do @(posedge clk); while (busy);
    sb.note_command(c);
    sent++;
  endtask

  task automatic drain();
    start <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8 * MAX_ENTRIES * MAX_ENTRIES) @(posedge clk);
  endtask

  task automatic write_buffer(logic [SIZE_W-1:0] v);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_buffer(v);
    @(posedge clk);
  endtask

  function automatic in_item_t mk(logic [1:0] op, logic [20:0] req,
                                  logic [19:0] fs);
    in_item_t c;
    c.operation = op;
    c.request_size = req;
    c.free_start = fs;
    return c;
  endfunction

  // pick a start that is currently allocated, or a random one
  function automatic logic [19:0] pick_start();
    int idx;
    if ($urandom_range(3) != 0)
      for (int t = 0; t < 8; t++) begin
        idx = $urandom_range(sb.tbl_count - 1);
        if (sb.tbl_used[idx]) return sb.tbl_start[idx];
      end
    return 20'($urandom);
  endfunction

  task automatic random_phase(int n, logic [SIZE_W-1:0] bsz);
    int r;
    logic [20:0] req;
    for (int k = 0; k < n; k++) begin
      quiet_stretch = (k >= n / 3 && k < n / 2);
      r = $urandom_range(99);
      if (r < 55) begin
        case ($urandom_range(9))
          0: req = 21'($urandom);
          1: req = 0;
          2: req = bsz;
          default: req = 21'($urandom_range(1, (bsz > 40) ? bsz / 20 : bsz));
        endcase
        send(mk(OP_ALLOC, req, 20'($urandom)));
      end else if (r < 88) begin
        send(mk(OP_FREE, 21'($urandom), pick_start()));
      end else if (r < 96) begin
        send(mk(OP_DEFRAG, 21'($urandom), 20'($urandom)));
      end else begin
        send(mk(2'd3, 21'($urandom), 20'($urandom)));
      end
    end
    quiet_stretch = 0;
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: reset-size buffer
    send(mk(OP_ALLOC, 0, 0));
    send(mk(OP_DEFRAG, 0, 0));
    send(mk(OP_FREE, 0, 0));
    send(mk(OP_ALLOC, 21'h1FFFFF, 20'hFFFFF));
    send(mk(OP_ALLOC, 100, 0));
    send(mk(OP_ALLOC, 200, 0));
    send(mk(OP_ALLOC, 300, 0));
    send(mk(OP_FREE, 0, 100));
    send(mk(OP_FREE, 0, 100));
    send(mk(OP_FREE, 0, 300));
    send(mk(OP_ALLOC, 250, 0));
    send(mk(2'd3, 21'h1FFFFF, 20'hFFFFF));
    send(mk(OP_DEFRAG, 0, 0));
    send(mk(OP_ALLOC, 65536, 0));
    drain();

    // minimum buffer, then fill the table to hit the full case
    write_buffer(0);
    send(mk(OP_ALLOC, 1, 0));
    send(mk(OP_ALLOC, 1, 0));
    drain();
    write_buffer(64);
    for (int i = 0; i < 33; i++) send(mk(OP_ALLOC, 1, 0));
    send(mk(OP_DEFRAG, 0, 0));
    send(mk(OP_FREE, 0, 20'd31));
    send(mk(OP_DEFRAG, 0, 0));
    drain();

    // maximum and beyond-range sizes
    write_buffer(BUF_CAP);
    send(mk(OP_ALLOC, BUF_CAP, 0));
    send(mk(OP_FREE, 0, 0));
    drain();
    write_buffer(21'h1FFFFF);
    random_phase(20, BUF_CAP);
    drain();
    write_buffer(1000);
    random_phase(40, 1000);
    drain();
    write_buffer(21'($urandom_range(1, 1 << 20)));
    random_phase(20, sb.buf_bytes);
    drain();

    $display("Sent %0d commands over several buffer sizes; checked %0d results.",
             sent, sb.results_seen);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end
endmodule

// ===== filelist.f =====
src/nfba_pkg.sv
src/nfba_ram.sv
src/next_fit_block_allocator_unit.sv
tb/sv/tb.sv
